[hw/rtl/whb_pkg.sv]
`default_nettype none
package whb_pkg;
   localparam int SumW = 48;
   localparam int IdxW = 6;
   localparam int AddrW = 12;
   localparam int ValW = 32;
   localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

   typedef enum logic [2:0] {
      FUNC_ACCUM = 3'd0,
      FUNC_CLEAR = 3'd1,
      FUNC_READ = 3'd2,
      FUNC_LOADX = 3'd3,
      FUNC_LOADY = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      CSR_BINS_X = 3'd0,
      CSR_BINS_Y = 3'd1,
      CSR_LOG_MODE = 3'd2,
      CSR_MASS = 3'd3,
      CSR_X_LO = 3'd4,
      CSR_X_INV = 3'd5,
      CSR_Y_LO = 3'd6,
      CSR_Y_INV = 3'd7
   } csr_type;

   typedef struct packed {
      logic start;
      logic [IdxW-1:0] n;
      logic use_log;
      logic signed [ValW-1:0] value;
      logic signed [ValW-1:0] lower;
      logic [ValW-1:0] inv_step;
   } bin_req_type;
endpackage
`default_nettype wire

[hw/rtl/whb_bin_search.sv]
`default_nettype none
// Bin finder for one axis. Linear: one 33x32 multiply, then clamp.
// Log: edge memory read per step, binary search, at most 8 reads.
module whb_bin_search (
   input wire logic clock,
   input wire logic reset,
   input wire whb_pkg::bin_req_type req,
   input wire logic edge_we,
   input wire logic [whb_pkg::IdxW-1:0] edge_addr,
   input wire logic [whb_pkg::ValW-1:0] edge_data,
   output logic done,
   output logic [whb_pkg::IdxW-1:0] bin
);
   import whb_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL = 5'b00010,
      S_LO = 5'b00100,
      S_HI = 5'b01000,
      S_SRCH = 5'b10000
   } st_type;

   logic [ValW-1:0] edge_mem [64];
   logic [ValW-1:0] rd_ff;
   logic [IdxW-1:0] raddr;

   st_type st_ff, st_in;
   logic [IdxW-1:0] lo_ff, lo_in, hi_ff, hi_in, bin_ff, bin_in;
   logic done_ff, done_in;
   logic [IdxW-1:0] n_ff;
   logic signed [ValW-1:0] v_ff;
   logic [ValW:0] d_ff;
   logic [ValW-1:0] inv_ff;
   logic below_ff;
   logic [2*ValW:0] prod;
   logic [ValW:0] q;
   logic ge;
   logic [IdxW-1:0] mid;
   logic [IdxW-1:0] mid_nx;

   assign ge = v_ff >= $signed(rd_ff);
   assign prod = d_ff * {1'b0, inv_ff};
   assign q = prod[2*ValW:ValW];
   assign mid = IdxW'((7'(lo_ff) + 7'(hi_ff)) >> 1);
   // probe point of the next step, so each search step costs one read
   assign mid_nx = IdxW'((7'(lo_in) + 7'(hi_in)) >> 1);

   always_comb begin
      case (st_ff)
         S_IDLE: raddr = '0;
         S_LO: raddr = n_ff;
         default: raddr = mid_nx;
      endcase
   end

   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_addr] <= edge_data;
      rd_ff <= edge_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         n_ff <= req.n;
         v_ff <= req.value;
         inv_ff <= req.inv_step;
         below_ff <= req.value < req.lower;
         d_ff <= (ValW+1)'(33'(signed'(req.value)) - 33'(signed'(req.lower)));
      end
   end

   always_comb begin
      st_in = st_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      bin_in = bin_ff;
      done_in = 1'b0;
      case (st_ff)
         S_IDLE: if (req.start) st_in = req.use_log ? S_LO : S_MUL;
         S_MUL: begin
            if (below_ff) bin_in = '0;
            else if (q >= (ValW+1)'(n_ff)) bin_in = n_ff + 1'b1;
            else bin_in = IdxW'(q) + 1'b1;
            done_in = 1'b1;
            st_in = S_IDLE;
         end
         S_LO: begin // rd = e[0]
            if (!ge) begin
               bin_in = '0;
               done_in = 1'b1;
               st_in = S_IDLE;
            end else st_in = S_HI;
            lo_in = '0;
            hi_in = n_ff;
         end
         S_HI: begin // rd = e[n]
            if (ge || hi_ff - lo_ff <= 1) begin
               bin_in = ge ? n_ff + 1'b1 : 6'd1;
               done_in = 1'b1;
               st_in = S_IDLE;
            end else st_in = S_SRCH;
         end
         S_SRCH: begin // rd = e[mid]
            if (ge) lo_in = mid;
            else hi_in = mid;
            if ((ge ? hi_ff - mid : mid - lo_ff) <= 1) begin
               bin_in = (ge ? mid : lo_ff) + 1'b1;
               done_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         done_ff <= done_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      bin_ff <= bin_in;
   end

   assign done = done_ff;
   assign bin = bin_ff;
endmodule
`default_nettype wire

[hw/rtl/whb_bin_store.sv]
`default_nettype none
// 4096x48 bin memory with registered read. Reset and clear zero it with a
// pass over every word, one word per cycle; busy is high during the pass.
module whb_bin_store (
   input wire logic clock,
   input wire logic reset,
   input wire logic clear,
   output logic busy,
   input wire logic rd_en,
   input wire logic [whb_pkg::AddrW-1:0] rd_addr,
   output logic [whb_pkg::SumW-1:0] rd_data,
   input wire logic wr_en,
   input wire logic [whb_pkg::AddrW-1:0] wr_addr,
   input wire logic [whb_pkg::SumW-1:0] wr_data
);
   import whb_pkg::*;

   logic [SumW-1:0] mem [1<<AddrW];
   logic [SumW-1:0] q_ff;
   logic clr_busy_ff;
   logic [AddrW-1:0] clr_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ptr_ff <= '0;
      end else if (clear) begin
         clr_busy_ff <= 1'b1;
         clr_ptr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_ptr_ff <= clr_ptr_ff + 1'b1;
         if (&clr_ptr_ff) clr_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) mem[clr_ptr_ff] <= '0;
      else if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) q_ff <= mem[rd_addr];
   end

   assign rd_data = q_ff;
   assign busy = clr_busy_ff;
endmodule
`default_nettype wire

[hw/rtl/weighted_histogram_binner_core.sv]
`default_nettype none
// channel | ports                               | handshake
// request | req_func .. req_edge_value          | start & !busy
// result  | rsp_bin_sum rsp_x_bin rsp_y_bin ..  | rsp_valid, one cycle
// csr     | csr_we csr_index csr_wdata          | csr_we
// Accumulate: x search, y search if bins_y is nonzero, store read, then
// add and write-back, with the result word strobed after the add. Read:
// store read, then the result word. Clear, load and unused codes answer
// with a zero word. Busy is high until the state machine is back in idle.
// Reset and clear start a pass that zeroes the store; busy stays high
// until it ends. The receiver cannot stall.
module weighted_histogram_binner_core #(
   parameter int MAX_BINS = 62
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [2:0] req_func,
   input wire logic signed [31:0] req_x_value,
   input wire logic signed [31:0] req_y_value,
   input wire logic [31:0] req_cell_volume,
   input wire logic [31:0] req_cell_density,
   input wire logic [5:0] req_x_index,
   input wire logic [5:0] req_y_index,
   input wire logic signed [31:0] req_edge_value,
   output logic rsp_valid,
   output logic [47:0] rsp_bin_sum,
   output logic [5:0] rsp_x_bin,
   output logic [5:0] rsp_y_bin,
   output logic rsp_saturated,
   input wire logic csr_we,
   input wire logic [2:0] csr_index,
   input wire logic [31:0] csr_wdata
);
   import whb_pkg::*;

   localparam int Lim = (MAX_BINS < 62) ? MAX_BINS : 62;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_X = 7'b0000010,
      S_Y = 7'b0000100,
      S_RD = 7'b0001000,
      S_ADD = 7'b0010000,
      S_OUT = 7'b0100000,
      S_INIT = 7'b1000000
   } st_type;

   logic [5:0] bins_x_ff, bins_y_ff;
   logic [1:0] log_ff;
   logic mass_ff;
   logic signed [31:0] xlo_ff, ylo_ff;
   logic [31:0] xinv_ff, yinv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_x_ff <= 6'd62;
         bins_y_ff <= '0;
         log_ff <= '0;
         mass_ff <= 1'b0;
         xlo_ff <= '0;
         xinv_ff <= 32'd65536;
         ylo_ff <= '0;
         yinv_ff <= 32'd65536;
      end else if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_BINS_X: bins_x_ff <= csr_wdata[5:0];
            CSR_BINS_Y: bins_y_ff <= csr_wdata[5:0];
            CSR_LOG_MODE: log_ff <= csr_wdata[1:0];
            CSR_MASS: mass_ff <= csr_wdata[0];
            CSR_X_LO: xlo_ff <= csr_wdata;
            CSR_X_INV: xinv_ff <= csr_wdata;
            CSR_Y_LO: ylo_ff <= csr_wdata;
            CSR_Y_INV: yinv_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic [5:0] eff_n(input logic [5:0] r);
      if (r == 0) eff_n = 6'd1;
      else if (32'(r) > Lim) eff_n = 6'(Lim);
      else eff_n = r;
   endfunction

   st_type st_ff;
   logic [2:0] func_ff;
   logic signed [31:0] yv_ff;
   logic [31:0] vol_ff, den_ff;
   logic [5:0] xb_ff, yb_ff;
   logic [47:0] w_ff;
   logic [63:0] wprod;
   logic [48:0] sum;

   logic xs_done, ys_done;
   logic [5:0] xs_bin, ys_bin;
   bin_req_type xreq, yreq;
   logic accept;

   assign accept = start && !busy;

   always_comb begin
      xreq.start = accept && req_func == FUNC_ACCUM;
      xreq.n = eff_n(bins_x_ff);
      xreq.use_log = log_ff[0];
      xreq.value = req_x_value;
      xreq.lower = xlo_ff;
      xreq.inv_step = xinv_ff;
      yreq.start = st_ff == S_X && xs_done && bins_y_ff != 0;
      yreq.n = eff_n(bins_y_ff);
      yreq.use_log = log_ff[1];
      yreq.value = yv_ff;
      yreq.lower = ylo_ff;
      yreq.inv_step = yinv_ff;
   end

   whb_bin_search u_xs (
      .clock(clock), .reset(reset), .req(xreq),
      .edge_we(accept && req_func == FUNC_LOADX), .edge_addr(req_x_index),
      .edge_data(req_edge_value), .done(xs_done), .bin(xs_bin)
   );
   whb_bin_search u_ys (
      .clock(clock), .reset(reset), .req(yreq),
      .edge_we(accept && req_func == FUNC_LOADY), .edge_addr(req_x_index),
      .edge_data(req_edge_value), .done(ys_done), .bin(ys_bin)
   );

   logic [47:0] rd_data;
   logic st_rd_en, st_wr_en;
   logic st_busy;
   logic [11:0] rd_addr;

   assign st_rd_en = st_ff == S_RD;
   assign rd_addr = {yb_ff, xb_ff};
   assign sum = {1'b0, rd_data} + {1'b0, w_ff};
   assign st_wr_en = st_ff == S_ADD && func_ff == FUNC_ACCUM;

   whb_bin_store u_store (
      .clock(clock), .reset(reset),
      .clear(accept && req_func == FUNC_CLEAR), .busy(st_busy),
      .rd_en(st_rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(st_wr_en), .wr_addr(rd_addr),
      .wr_data(sum[48] ? SumMax : sum[47:0])
   );

   assign wprod = vol_ff * den_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         yv_ff <= req_y_value;
         vol_ff <= req_cell_volume;
         den_ff <= req_cell_density;
         xb_ff <= req_x_index;
         yb_ff <= req_y_index;
      end
      if (st_ff == S_X) begin
         w_ff <= mass_ff ? wprod[63:16] : {16'd0, vol_ff};
         if (xs_done) begin
            xb_ff <= xs_bin;
            yb_ff <= '0;
         end
      end
      if (st_ff == S_Y && ys_done) yb_ff <= ys_bin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_INIT;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (st_ff)
            S_INIT: begin
               // wait out the store's initialization pass
               if (!st_busy) st_ff <= S_IDLE;
            end
            S_IDLE: if (accept) begin
               case (func_type'(req_func))
                  FUNC_ACCUM: st_ff <= S_X;
                  FUNC_READ: st_ff <= S_RD;
                  default: st_ff <= S_OUT;
               endcase
            end
            S_X: if (xs_done) st_ff <= (bins_y_ff != 0) ? S_Y : S_RD;
            S_Y: if (ys_done) st_ff <= S_RD;
            S_RD: st_ff <= S_ADD;
            S_ADD: begin
               rsp_valid <= 1'b1;
               rsp_x_bin <= xb_ff;
               rsp_y_bin <= yb_ff;
               if (func_ff == FUNC_ACCUM) begin
                  rsp_bin_sum <= sum[48] ? SumMax : sum[47:0];
                  rsp_saturated <= sum[48];
               end else begin
                  rsp_bin_sum <= rd_data;
                  rsp_saturated <= 1'b0;
               end
               st_ff <= S_IDLE;
            end
            S_OUT: begin
               rsp_valid <= 1'b1;
               rsp_bin_sum <= '0;
               rsp_x_bin <= '0;
               rsp_y_bin <= '0;
               rsp_saturated <= 1'b0;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = st_ff != S_IDLE || st_busy;
endmodule
`default_nettype wire

[hw/rtl/whb_checker.sv]
`default_nettype none
module whb_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_saturated,
   input wire logic [47:0] rsp_bin_sum
);
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result word repeated");
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> &rsp_bin_sum) else $error("sat sum");
   a_no_idle_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("word without work");
endmodule

bind weighted_histogram_binner_core whb_checker u_whb_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_saturated(rsp_saturated),
   .rsp_bin_sum(rsp_bin_sum)
);
`default_nettype wire

[dv/tb_weighted_histogram_binner_core.sv]
`timescale 1ns / 100ps
module tb_weighted_histogram_binner_core;
   import whb_pkg::*;

   localparam int BinLimit = 62;
   localparam int IdleLimit = 20000;
   localparam logic [2:0] FUNC_SPARE5 = 3'd5;
   localparam logic [2:0] FUNC_SPARE6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE7 = 3'd7;

   typedef struct {
      logic [2:0] func;
      logic [31:0] x_value;
      logic [31:0] y_value;
      logic [31:0] volume;
      logic [31:0] density;
      logic [5:0] x_index;
      logic [5:0] y_index;
      logic [31:0] edge_value;
   } sample_word_type;

   typedef struct {
      logic [47:0] sum;
      logic [5:0] x_bin;
      logic [5:0] y_bin;
      logic sat;
   } bin_word_type;

   typedef struct {
      sample_word_type w;
      bit fixed;
      bin_word_type r;
   } stim_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_func = '0;
   logic signed [31:0] req_x_value = '0;
   logic signed [31:0] req_y_value = '0;
   logic [31:0] req_cell_volume = '0;
   logic [31:0] req_cell_density = '0;
   logic [5:0] req_x_index = '0;
   logic [5:0] req_y_index = '0;
   logic signed [31:0] req_edge_value = '0;
   logic rsp_valid;
   logic [47:0] rsp_bin_sum;
   logic [5:0] rsp_x_bin;
   logic [5:0] rsp_y_bin;
   logic rsp_saturated;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   always #5 clock = ~clock;

   weighted_histogram_binner_core u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_x_value(req_x_value),
      .req_y_value(req_y_value),
      .req_cell_volume(req_cell_volume),
      .req_cell_density(req_cell_density),
      .req_x_index(req_x_index),
      .req_y_index(req_y_index),
      .req_edge_value(req_edge_value),
      .rsp_valid(rsp_valid),
      .rsp_bin_sum(rsp_bin_sum),
      .rsp_x_bin(rsp_x_bin),
      .rsp_y_bin(rsp_y_bin),
      .rsp_saturated(rsp_saturated),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // shadow of the block's registers and storage
   logic [5:0] cfg_bins_x = 6'd62;
   logic [5:0] cfg_bins_y = 6'd0;
   logic [1:0] cfg_log = 2'd0;
   logic cfg_mass = 1'b0;
   logic [31:0] cfg_x_lo = '0;
   logic [31:0] cfg_x_inv = 32'h10000;
   logic [31:0] cfg_y_lo = '0;
   logic [31:0] cfg_y_inv = 32'h10000;
   logic [47:0] bin_totals [4096];
   logic [31:0] x_edges [64];
   logic [31:0] y_edges [64];

   stim_entry_type stim_q[$];
   bin_word_type bin_expect_q[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit heavy = 0;

   initial begin
      for (int i = 0; i < 4096; i++) bin_totals[i] = '0;
      for (int i = 0; i < 64; i++) begin
         x_edges[i] = '0;
         y_edges[i] = '0;
      end
   end

   function automatic int unsigned clamp_bins(logic [5:0] r);
      int unsigned n;
      n = r;
      if (n < 1) n = 1;
      if (n > BinLimit) n = BinLimit;
      return n;
   endfunction

   function automatic int unsigned linear_bin(longint v, longint lo, logic [31:0] inv,
                                              int unsigned n);
      logic [63:0] d;
      logic [63:0] prod;
      logic [63:0] q;
      if (v < lo) return 0;
      d = v - lo;
      prod = d * {32'd0, inv};
      q = prod >> 32;
      return (q >= n) ? n + 1 : int'(q) + 1;
   endfunction

   function automatic longint sx(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   function automatic int unsigned search_bin(longint v, bit y_axis, int unsigned n);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      logic [31:0] e0;
      logic [31:0] en;
      lo = 0;
      hi = n;
      e0 = y_axis ? y_edges[0] : x_edges[0];
      en = y_axis ? y_edges[n] : x_edges[n];
      if (v < sx(e0)) return 0;
      if (v >= sx(en)) return n + 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (v >= sx(y_axis ? y_edges[mid] : x_edges[mid])) lo = mid;
         else hi = mid;
      end
      return lo + 1;
   endfunction

   function automatic bin_word_type predict_bin_word(sample_word_type w);
      bin_word_type r;
      int unsigned xb;
      int unsigned yb;
      logic [63:0] wt;
      logic [63:0] acc;
      int addr;
      r = '{default: '0};
      case (w.func)
         FUNC_ACCUM: begin
            if (cfg_log[0]) xb = search_bin(sx(w.x_value), 0, clamp_bins(cfg_bins_x));
            else xb = linear_bin(sx(w.x_value), sx(cfg_x_lo), cfg_x_inv,
                                 clamp_bins(cfg_bins_x));
            yb = 0;
            if (cfg_bins_y != 0) begin
               if (cfg_log[1]) yb = search_bin(sx(w.y_value), 1, clamp_bins(cfg_bins_y));
               else yb = linear_bin(sx(w.y_value), sx(cfg_y_lo), cfg_y_inv,
                                    clamp_bins(cfg_bins_y));
            end
            wt = cfg_mass ? (({32'd0, w.volume} * {32'd0, w.density}) >> 16)
                          : {32'd0, w.volume};
            addr = (yb % 64) * 64 + (xb % 64);
            acc = {16'd0, bin_totals[addr]} + wt;
            if (acc > {16'd0, SumMax}) begin
               acc = {16'd0, SumMax};
               r.sat = 1'b1;
            end
            bin_totals[addr] = acc[47:0];
            r.sum = acc[47:0];
            r.x_bin = xb[5:0];
            r.y_bin = yb[5:0];
         end
         FUNC_CLEAR: for (int i = 0; i < 4096; i++) bin_totals[i] = '0;
         FUNC_READ: begin
            r.sum = bin_totals[w.y_index * 64 + w.x_index];
            r.x_bin = w.x_index;
            r.y_bin = w.y_index;
         end
         FUNC_LOADX: x_edges[w.x_index] = w.edge_value;
         FUNC_LOADY: y_edges[w.x_index] = w.edge_value;
         default: ;
      endcase
      return r;
   endfunction

   function automatic sample_word_type mk(logic [2:0] f, logic [31:0] xv, logic [31:0] yv,
                                          logic [31:0] vol, logic [31:0] den,
                                          logic [5:0] xi, logic [5:0] yi,
                                          logic [31:0] ev);
      sample_word_type w;
      w.func = f;
      w.x_value = xv;
      w.y_value = yv;
      w.volume = vol;
      w.density = den;
      w.x_index = xi;
      w.y_index = yi;
      w.edge_value = ev;
      return w;
   endfunction

   task automatic push(sample_word_type w, bit fixed = 0,
                       bin_word_type r = '{default: '0});
      stim_entry_type s;
      s.w = w;
      s.fixed = fixed;
      s.r = r;
      stim_q.push_back(s);
   endtask

   function automatic bin_word_type bw(logic [47:0] s, logic [5:0] xb, logic [5:0] yb,
                                       logic sat);
      bin_word_type r;
      r.sum = s;
      r.x_bin = xb;
      r.y_bin = yb;
      r.sat = sat;
      return r;
   endfunction

   // value aimed at the interesting range of one axis
   function automatic logic [31:0] pick_value(bit y_axis);
      int unsigned n;
      longint lo_v;
      longint span;
      longint v;
      logic [63:0] rnd;
      logic [31:0] inv;
      if ($urandom_range(0, 5) == 0) return $urandom;
      n = clamp_bins(y_axis ? cfg_bins_y : cfg_bins_x);
      rnd = {$urandom, $urandom};
      if (cfg_log[y_axis]) begin
         lo_v = sx(y_axis ? y_edges[0] : x_edges[0]);
         span = sx(y_axis ? y_edges[n] : x_edges[n]) - lo_v;
      end else begin
         lo_v = sx(y_axis ? cfg_y_lo : cfg_x_lo);
         inv = y_axis ? cfg_y_inv : cfg_x_inv;
         span = (inv == 0) ? 64'd1 << 20 : ((longint'(n) + 2) << 32) / inv;
      end
      if (span <= 0) span = 1;
      if (span > (64'd1 << 32)) span = 64'd1 << 32;
      v = lo_v - span / 8 + longint'(rnd % (span * 5 / 4 + 1));
      return v[31:0];
   endfunction

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return heavy ? ($urandom | 32'hFFFF0000)
                               : ($urandom >> $urandom_range(0, 16));
      endcase
   endfunction

   function automatic sample_word_type random_word();
      int unsigned sel;
      logic [2:0] f;
      sel = $urandom_range(0, 99);
      if (sel < 66) f = FUNC_ACCUM;
      else if (sel < 82) f = FUNC_READ;
      else if (sel < 84) f = FUNC_CLEAR;
      else if (sel < 90) f = FUNC_LOADX;
      else if (sel < 96) f = FUNC_LOADY;
      else f = 3'($urandom_range(5, 7));
      return mk(f, pick_value(0), pick_value(1), pick_weight(), pick_weight(),
                6'($urandom), 6'($urandom), $urandom);
   endfunction

   // request driver: bursts with random gaps
   int burst_left = 4;
   int gap_left = 0;
   sample_word_type cur;
   always @(posedge clock) begin
      bit go;
      bin_word_type p;
      go = start;
      if (!reset && start && !busy) begin
         p = predict_bin_word(cur);
         bin_expect_q.push_back(stim_q[0].fixed ? stim_q[0].r : p);
         stim_q.pop_front();
         go = 0;
      end
      if (!reset && !go) begin
         if (gap_left > 0) gap_left--;
         else if (stim_q.size() > 0) begin
            cur = stim_q[0].w;
            req_func <= cur.func;
            req_x_value <= cur.x_value;
            req_y_value <= cur.y_value;
            req_cell_volume <= cur.volume;
            req_cell_density <= cur.density;
            req_x_index <= cur.x_index;
            req_y_index <= cur.y_index;
            req_edge_value <= cur.edge_value;
            go = 1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
      start <= go;
   end

   // result check and watchdog
   always @(posedge clock) begin
      bin_word_type e;
      idle_cycles++;
      if ((start && !busy) || csr_we) idle_cycles = 0;
      if (!reset && rsp_valid) begin
         idle_cycles = 0;
         if (bin_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: sum=%h x=%0d y=%0d sat=%b",
                                           rsp_bin_sum, rsp_x_bin, rsp_y_bin, rsp_saturated);
         end else begin
            e = bin_expect_q.pop_front();
            if (rsp_bin_sum !== e.sum || rsp_x_bin !== e.x_bin || rsp_y_bin !== e.y_bin ||
                rsp_saturated !== e.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"word mismatch: exp sum=%h x=%0d y=%0d sat=%b ",
                            "got sum=%h x=%0d y=%0d sat=%b"},
                           e.sum, e.x_bin, e.y_bin, e.sat,
                           rsp_bin_sum, rsp_x_bin, rsp_y_bin, rsp_saturated);
            end
         end
      end
      if (idle_cycles > IdleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_reg(csr_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_BINS_X: cfg_bins_x = val[5:0];
         CSR_BINS_Y: cfg_bins_y = val[5:0];
         CSR_LOG_MODE: cfg_log = val[1:0];
         CSR_MASS: cfg_mass = val[0];
         CSR_X_LO: cfg_x_lo = val;
         CSR_X_INV: cfg_x_inv = val;
         CSR_Y_LO: cfg_y_lo = val;
         CSR_Y_INV: cfg_y_inv = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (stim_q.size() > 0 || start || bin_expect_q.size() > 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic load_edges(logic [2:0] f);
      longint base;
      longint step;
      longint v;
      base = -longint'($urandom_range(0, 1 << 24));
      step = $urandom_range(1, 1 << 20);
      for (int k = 0; k < 64; k++) begin
         v = base + k * step;
         push(mk(f, '0, '0, '0, '0, 6'(k), '0, v[31:0]));
      end
   endtask

   initial begin
      logic [31:0] cfg [8];
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows at reset settings: 1D, linear, edge 0, step 1.0, 62 bins
      push(mk(FUNC_READ, '0, '0, '0, '0, 6'd0, 6'd0, '0), 1, bw('0, 0, 0, 0));
      push(mk(FUNC_READ, '0, '0, '0, '0, 6'd63, 6'd63, '0), 1, bw('0, 63, 63, 0));
      push(mk(FUNC_ACCUM, '0, '0, 32'h10000, '0, '0, '0, '0), 1, bw(48'h10000, 1, 0, 0));
      push(mk(FUNC_ACCUM, '1, '0, '1, '0, '0, '0, '0), 1, bw(48'hFFFFFFFF, 0, 0, 0));
      push(mk(FUNC_ACCUM, 32'h7FFFFFFF, '0, '0, '0, '0, '0, '0), 1, bw('0, 63, 0, 0));
      push(mk(FUNC_ACCUM, 32'h80000000, '0, 32'd1, '0, '0, '0, '0), 1,
           bw(48'h1_0000_0000, 0, 0, 0));
      push(mk(FUNC_ACCUM, 32'h3D0000, '0, 32'h20000, '0, '0, '0, '0), 1,
           bw(48'h20000, 62, 0, 0));
      push(mk(FUNC_ACCUM, 32'h3E0000, '0, 32'd5, '0, '0, '0, '0), 1, bw(48'd5, 63, 0, 0));
      // y ignored in 1D
      push(mk(FUNC_ACCUM, 32'h18000, 32'h7FFFFFFF, 32'd7, '1, '1, '1, '1), 1,
           bw(48'd7, 2, 0, 0));
      push(mk(FUNC_READ, '0, '0, '0, '0, 6'd1, 6'd0, '0), 1, bw(48'h10000, 1, 0, 0));
      push(mk(FUNC_READ, '1, '1, '1, '1, 6'd0, 6'd0, '1), 1, bw(48'h1_0000_0000, 0, 0, 0));
      push(mk(FUNC_LOADX, '0, '0, '0, '0, 6'd63, '0, 32'h80000000), 1, bw('0, 0, 0, 0));
      push(mk(FUNC_LOADY, '0, '0, '0, '0, 6'd0, 6'd63, 32'h7FFFFFFF), 1, bw('0, 0, 0, 0));
      push(mk(FUNC_SPARE5, '1, '1, '1, '1, '1, '1, '1), 1, bw('0, 0, 0, 0));
      push(mk(FUNC_SPARE6, '1, '1, '1, '1, '1, '1, '1), 1, bw('0, 0, 0, 0));
      push(mk(FUNC_SPARE7, '1, '1, '1, '1, '1, '1, '1), 1, bw('0, 0, 0, 0));
      push(mk(FUNC_READ, '0, '0, '0, '0, 6'd62, 6'd0, '0));
      push(mk(FUNC_CLEAR, '1, '1, '1, '1, '1, '1, '1), 1, bw('0, 0, 0, 0));
      push(mk(FUNC_READ, '0, '0, '0, '0, 6'd63, 6'd0, '0), 1, bw('0, 63, 0, 0));
      push(mk(FUNC_ACCUM, 32'h10000, '0, 32'd1, '1, '0, '0, '0), 1, bw(48'd1, 2, 0, 0));
      drain();

      // fill both edge tables so log searches never touch an unwritten slot
      load_edges(FUNC_LOADX);
      load_edges(FUNC_LOADY);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: cfg = '{32'd0, 32'd63, 32'd0, 32'd1, 32'h80000000, '1, 32'h7FFFFFFF, '0};
            1: cfg = '{32'd63, 32'd62, 32'd3, 32'd1, '0, 32'h10000, '0, 32'h10000};
            2: cfg = '{32'd1, 32'd1, 32'd1, 32'd0, 32'hFFFF0000, 32'h8000, '0, '0};
            default: cfg = '{$urandom, $urandom_range(0, 63), $urandom_range(0, 3),
                             $urandom_range(0, 1), $urandom >> $urandom_range(0, 31),
                             $urandom >> $urandom_range(0, 31),
                             $urandom >> $urandom_range(0, 31),
                             $urandom >> $urandom_range(0, 31)};
         endcase
         heavy = (ph == 1) || ($urandom_range(0, 2) == 0);
         for (int r = 0; r < 8; r++) write_reg(csr_type'(r), cfg[r]);
         for (int i = 0; i < 125; i++) push(random_word());
         drain();
      end

      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

[files.f]
hw/rtl/whb_pkg.sv
hw/rtl/whb_bin_search.sv
hw/rtl/whb_bin_store.sv
hw/rtl/weighted_histogram_binner_core.sv
hw/rtl/whb_checker.sv
dv/tb_weighted_histogram_binner_core.sv
